// ===== hdl/sti_pkg.sv =====
package sti_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 4;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SHOW   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        t_action                       action;
        logic signed [VALUE_WIDTH-1:0] value;
    } t_in_word;

    typedef struct packed {
        t_status                       status;
        logic signed [VALUE_WIDTH-1:0] entry_value;
        logic [POS_W-1:0]              entry_position;
        logic                          last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_CMP,
        S_DEL_CMP,
        S_DEL_SHIFT,
        S_SHOW_OUT
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_COUNT,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [1:0] {
        RD_MINUS1,
        RD_SAME,
        RD_PLUS1
    } t_rd_off;

    typedef enum logic {
        WR_DATA,
        WR_VALUE
    } t_wr_sel;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } t_cnt_op;

    typedef enum logic [1:0] {
        VS_INPUT,
        VS_HELD,
        VS_DATA,
        VS_ZERO
    } t_val_sel;

    typedef enum logic [1:0] {
        PS_INDEX,
        PS_HELD,
        PS_ZERO
    } t_pos_sel;

    typedef struct packed {
        logic     load;
        t_idx_op  idx_op;
        t_rd_off  rd_off;
        logic     mem_we;
        t_wr_sel  wr_sel;
        t_cnt_op  cnt_op;
        logic     pos_cap;
        logic     emit;
        t_status  status;
        t_val_sel val_sel;
        t_pos_sel pos_sel;
        logic     last;
    } t_cmd;

    typedef struct packed {
        logic data_gt;
        logic data_eq;
        logic idx_zero;
        logic idx_p1_lt_cnt;
        logic idx_p2_lt_cnt;
        logic cnt_zero;
        logic full;
    } t_sts;

endpackage

// ===== hdl/sorted_table_insert_delete_core.sv =====
// Sorted table of up to 16 signed 32-bit values, kept in ascending order.
// Command word in: action (insert, delete, show) and value, taken at a rising
// edge with start high and busy low. Result words out: one cycle each on
// o_result, marked by o_strobe; the receiver must take every word as it comes.
// Insert: walks down from the top entry, moving larger entries up one slot a
// cycle; busy stays high until the value is written at its sorted position.
// A full table gives a single "full" word the cycle after the command, with
// busy never raised.
// Delete: scans up from the bottom for the first equal entry, then moves the
// entries behind it down one slot a cycle. No match gives a single "not
// found" word.
// Show: one word per entry, back to back, the final one flagged last. An
// empty table gives a single "empty" word.
// Each result word is registered and appears in the cycle after the step that
// makes it; a new command may be taken while that word is still on the ports.
// Reset clears the entry count and the state machine; table contents are left
// as they were, and entries above the count may be read but are never used.
module sorted_table_insert_delete_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sti_pkg::t_in_word  i_word,
    output logic               busy,
    output logic               o_strobe,
    output sti_pkg::t_out_word o_result
);

    sti_pkg::t_cmd w_cmd;
    sti_pkg::t_sts w_sts;

    // sequence each command: walk, compare and move entries
    sti_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_word.action),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // hold table, index, count and the registered result word
    sti_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

`ifndef ASSERT_OFF
    // never write the table while waiting for a command
    a_write_only_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mem_we |-> busy)
        else $error("table written outside a command");

    // a show stream runs without gaps until its last word
    a_show_no_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last) |=> o_strobe)
        else $error("result stream broken before last word");

    // insert into a full table answers at once with a full word
    a_full_reply : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_word.action == sti_pkg::ACT_INSERT && w_sts.full)
        |=> (o_strobe && o_result.status == sti_pkg::ST_FULL && !busy))
        else $error("full table insert not refused");

    // the entry count never passes the table depth
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sts.full && busy) |-> !w_cmd.mem_we || w_cmd.cnt_op != sti_pkg::CNT_INC)
        else $error("entry count overflow");
`endif

endmodule

// ===== hdl/sti_datapath.sv =====
module sti_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sti_pkg::t_in_word i_word,
    input  sti_pkg::t_cmd     i_cmd,
    output sti_pkg::t_sts     o_sts,
    output logic              o_strobe,
    output sti_pkg::t_out_word o_result
);

    logic [sti_pkg::VALUE_WIDTH-1:0] r_mem [sti_pkg::TABLE_DEPTH];

    logic [sti_pkg::VALUE_WIDTH-1:0] r_rd_data;
    logic [sti_pkg::VALUE_WIDTH-1:0] r_value, n_value;
    logic [sti_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic [sti_pkg::CNT_W-1:0]       r_count, n_count;
    logic [sti_pkg::POS_W-1:0]       r_pos, n_pos;
    logic                            r_strobe, n_strobe;
    sti_pkg::t_out_word              r_result, n_result;

    logic [sti_pkg::CNT_W-1:0]       w_rd_full;
    logic [sti_pkg::ADDR_W-1:0]      w_rd_addr;
    logic [sti_pkg::VALUE_WIDTH-1:0] w_wr_data;
    logic [sti_pkg::CNT_W:0]         w_idx_p1;
    logic [sti_pkg::CNT_W:0]         w_idx_p2;

    // status towards the controller
    always_comb begin
        w_idx_p1 = {1'b0, r_idx} + (sti_pkg::CNT_W+1)'(1);
        w_idx_p2 = {1'b0, r_idx} + (sti_pkg::CNT_W+1)'(2);
        o_sts.data_gt       = $signed(r_rd_data) > $signed(r_value);
        o_sts.data_eq       = r_rd_data == r_value;
        o_sts.idx_zero      = r_idx == '0;
        o_sts.idx_p1_lt_cnt = w_idx_p1 < {1'b0, r_count};
        o_sts.idx_p2_lt_cnt = w_idx_p2 < {1'b0, r_count};
        o_sts.cnt_zero      = r_count == '0;
        o_sts.full          = r_count >= sti_pkg::CNT_W'(sti_pkg::TABLE_DEPTH);
    end

    always_comb begin
        n_value = i_cmd.load ? i_word.value : r_value;

        case (i_cmd.idx_op)
            sti_pkg::IDX_ZERO:  n_idx = '0;
            sti_pkg::IDX_COUNT: n_idx = r_count;
            sti_pkg::IDX_INC:   n_idx = r_idx + sti_pkg::CNT_W'(1);
            sti_pkg::IDX_DEC:   n_idx = r_idx - sti_pkg::CNT_W'(1);
            default:            n_idx = r_idx;
        endcase

        case (i_cmd.rd_off)
            sti_pkg::RD_MINUS1: w_rd_full = n_idx - sti_pkg::CNT_W'(1);
            sti_pkg::RD_PLUS1:  w_rd_full = n_idx + sti_pkg::CNT_W'(1);
            default:            w_rd_full = n_idx;
        endcase
        w_rd_addr = w_rd_full[sti_pkg::ADDR_W-1:0];

        w_wr_data = (i_cmd.wr_sel == sti_pkg::WR_DATA) ? r_rd_data : r_value;

        case (i_cmd.cnt_op)
            sti_pkg::CNT_INC: n_count = r_count + sti_pkg::CNT_W'(1);
            sti_pkg::CNT_DEC: n_count = r_count - sti_pkg::CNT_W'(1);
            default:          n_count = r_count;
        endcase

        n_pos = i_cmd.pos_cap ? r_idx[sti_pkg::POS_W-1:0] : r_pos;

        n_strobe = i_cmd.emit;
        n_result.status = i_cmd.status;
        n_result.last   = i_cmd.last;
        case (i_cmd.val_sel)
            sti_pkg::VS_INPUT: n_result.entry_value = i_word.value;
            sti_pkg::VS_HELD:  n_result.entry_value = r_value;
            sti_pkg::VS_DATA:  n_result.entry_value = r_rd_data;
            default:           n_result.entry_value = '0;
        endcase
        case (i_cmd.pos_sel)
            sti_pkg::PS_INDEX: n_result.entry_position = r_idx[sti_pkg::POS_W-1:0];
            sti_pkg::PS_HELD:  n_result.entry_position = r_pos;
            default:           n_result.entry_position = '0;
        endcase
    end

    // table storage: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[r_idx[sti_pkg::ADDR_W-1:0]] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
        r_value  <= n_value;
        r_idx    <= n_idx;
        r_pos    <= n_pos;
        r_result <= n_result;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== hdl/sti_controller.sv =====
module sti_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  sti_pkg::t_action i_action,
    input  sti_pkg::t_sts    i_sts,
    output sti_pkg::t_cmd    o_cmd,
    output logic             o_busy
);

    sti_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.load    = 1'b0;
        o_cmd.idx_op  = sti_pkg::IDX_HOLD;
        o_cmd.rd_off  = sti_pkg::RD_SAME;
        o_cmd.mem_we  = 1'b0;
        o_cmd.wr_sel  = sti_pkg::WR_DATA;
        o_cmd.cnt_op  = sti_pkg::CNT_HOLD;
        o_cmd.pos_cap = 1'b0;
        o_cmd.emit    = 1'b0;
        o_cmd.status  = sti_pkg::ST_OK;
        o_cmd.val_sel = sti_pkg::VS_HELD;
        o_cmd.pos_sel = sti_pkg::PS_ZERO;
        o_cmd.last    = 1'b1;

        unique case (r_state)
            sti_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_action)
                        sti_pkg::ACT_INSERT: begin
                            if (i_sts.full) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.status  = sti_pkg::ST_FULL;
                                o_cmd.val_sel = sti_pkg::VS_INPUT;
                            end else begin
                                // walk down from the top entry
                                o_cmd.idx_op = sti_pkg::IDX_COUNT;
                                o_cmd.rd_off = sti_pkg::RD_MINUS1;
                                n_state      = sti_pkg::S_INS_CMP;
                            end
                        end
                        sti_pkg::ACT_DELETE: begin
                            if (i_sts.cnt_zero) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.status  = sti_pkg::ST_NOTFOUND;
                                o_cmd.val_sel = sti_pkg::VS_INPUT;
                            end else begin
                                o_cmd.idx_op = sti_pkg::IDX_ZERO;
                                n_state      = sti_pkg::S_DEL_CMP;
                            end
                        end
                        sti_pkg::ACT_SHOW: begin
                            if (i_sts.cnt_zero) begin
                                o_cmd.emit    = 1'b1;
                                o_cmd.status  = sti_pkg::ST_EMPTY;
                                o_cmd.val_sel = sti_pkg::VS_ZERO;
                            end else begin
                                o_cmd.idx_op = sti_pkg::IDX_ZERO;
                                n_state      = sti_pkg::S_SHOW_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            sti_pkg::S_INS_CMP: begin
                if (!i_sts.idx_zero && i_sts.data_gt) begin
                    // move the larger entry up one slot
                    o_cmd.mem_we = 1'b1;
                    o_cmd.wr_sel = sti_pkg::WR_DATA;
                    o_cmd.idx_op = sti_pkg::IDX_DEC;
                    o_cmd.rd_off = sti_pkg::RD_MINUS1;
                end else begin
                    o_cmd.mem_we  = 1'b1;
                    o_cmd.wr_sel  = sti_pkg::WR_VALUE;
                    o_cmd.cnt_op  = sti_pkg::CNT_INC;
                    o_cmd.emit    = 1'b1;
                    o_cmd.pos_sel = sti_pkg::PS_INDEX;
                    n_state       = sti_pkg::S_IDLE;
                end
            end
            sti_pkg::S_DEL_CMP: begin
                if (i_sts.data_eq) begin
                    if (i_sts.idx_p1_lt_cnt) begin
                        o_cmd.pos_cap = 1'b1;
                        o_cmd.rd_off  = sti_pkg::RD_PLUS1;
                        n_state       = sti_pkg::S_DEL_SHIFT;
                    end else begin
                        o_cmd.cnt_op  = sti_pkg::CNT_DEC;
                        o_cmd.emit    = 1'b1;
                        o_cmd.pos_sel = sti_pkg::PS_INDEX;
                        n_state       = sti_pkg::S_IDLE;
                    end
                end else if (i_sts.idx_p1_lt_cnt) begin
                    o_cmd.idx_op = sti_pkg::IDX_INC;
                end else begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.status = sti_pkg::ST_NOTFOUND;
                    n_state      = sti_pkg::S_IDLE;
                end
            end
            sti_pkg::S_DEL_SHIFT: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wr_sel = sti_pkg::WR_DATA;
                if (i_sts.idx_p2_lt_cnt) begin
                    o_cmd.idx_op = sti_pkg::IDX_INC;
                    o_cmd.rd_off = sti_pkg::RD_PLUS1;
                end else begin
                    o_cmd.cnt_op  = sti_pkg::CNT_DEC;
                    o_cmd.emit    = 1'b1;
                    o_cmd.pos_sel = sti_pkg::PS_HELD;
                    n_state       = sti_pkg::S_IDLE;
                end
            end
            sti_pkg::S_SHOW_OUT: begin
                o_cmd.emit    = 1'b1;
                o_cmd.val_sel = sti_pkg::VS_DATA;
                o_cmd.pos_sel = sti_pkg::PS_INDEX;
                o_cmd.last    = !i_sts.idx_p1_lt_cnt;
                if (i_sts.idx_p1_lt_cnt) begin
                    o_cmd.idx_op = sti_pkg::IDX_INC;
                end else begin
                    n_state = sti_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sti_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy = r_state != sti_pkg::S_IDLE;

endmodule
